@@ sv/caef_pkg.sv @@
package caef_pkg;

    localparam int OUTER_ROW_CHANNELS_DEF = 20;
    localparam int SQRT3_HALF_Q16 = 56756;

    localparam int POS_W   = 15;
    localparam int OUT_W   = 23;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 22;
    localparam int CX_W    = 33;
    localparam int CY_W    = 27;
    localparam int CHORD_W = 40;
    localparam int ACC_W   = 48;

    localparam logic [15:0] DIAMETER_RST  = 16'd6144;
    localparam logic [15:0] PITCH_RST     = 16'd8192;
    localparam logic [21:0] THICKNESS_RST = 22'd614400;
    localparam logic [16:0] TAN_RST       = 17'd13930;
    localparam logic [16:0] SEC_RST       = 17'd66997;
    localparam logic [21:0] COT_RST       = 22'd308325;
    localparam logic [21:0] CSC_RST       = 22'd315211;

    typedef enum logic [IDX_W-1:0] {
        REG_DIAMETER  = 3'd0,
        REG_PITCH     = 3'd1,
        REG_THICKNESS = 3'd2,
        REG_TAN       = 3'd3,
        REG_SEC       = 3'd4,
        REG_COT       = 3'd5,
        REG_CSC       = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] diameter;
        logic [15:0] pitch;
        logic [21:0] thickness;
        logic [16:0] tan_a;
        logic [16:0] sec_a;
        logic [21:0] cot_a;
        logic [21:0] csc_a;
    } cfg_t;

endpackage

@@ sv/caef_chord.sv @@
module caef_chord
    import caef_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic                       in_last,
    input  logic signed [POS_W-1:0]    x_in,
    input  logic signed [POS_W-1:0]    y_in,
    input  logic signed [CX_W-1:0]     cx_in,
    input  logic signed [CY_W-1:0]     cy_in,
    input  cfg_t                       cfg,
    output logic                       chord_valid,
    output logic                       chord_last,
    output logic [CHORD_W-1:0]         chord
);

    localparam int SQ_N = 13;

    typedef struct packed {
        logic [27:0] rem;
        logic [25:0] root;
    } sq_t;

    typedef struct packed {
        logic signed [24:0]     x;
        logic signed [CX_W-1:0] cx;
        logic [32:0]            h;
        logic                   band;
        logic                   last;
    } side_t;

    typedef enum logic [1:0] {
        M_ZERO  = 2'd0,
        M_SLANT = 2'd1,
        M_FULL  = 2'd2,
        M_RAMP  = 2'd3
    } mode_t;

    function automatic sq_t sq_step(sq_t a, logic [1:0] b);
        logic [29:0] remt;
        logic [29:0] trial;
        sq_t         r;
        remt  = {a.rem, b};
        trial = {2'b00, a.root, 2'b01};
        if (remt >= trial)
        begin
            r.rem  = 28'(remt - trial);
            r.root = {a.root[24:0], 1'b1};
        end
        else
        begin
            r.rem  = remt[27:0];
            r.root = {a.root[24:0], 1'b0};
        end
        return r;
    endfunction

    logic [25:0] dq;
    assign dq = {cfg.diameter, 10'b0};

    // stage 1: band test, offset, half-shift product
    logic signed [24:0] x20;
    logic signed [24:0] y20;
    logic signed [27:0] dy;
    logic [27:0]        ady;

    assign x20 = {x_in, 10'b0};
    assign y20 = {y_in, 10'b0};
    assign dy  = $signed({{3{y20[24]}}, y20}) - $signed({cy_in[CY_W-1], cy_in});
    assign ady = dy[27] ? 28'(-dy) : 28'(dy);

    logic                   s1_v_reg;
    logic signed [24:0]     s1_x_reg;
    logic signed [CX_W-1:0] s1_cx_reg;
    logic                   s1_band_reg;
    logic                   s1_last_reg;
    logic [25:0]            s1_t2_reg;
    logic [38:0]            s1_hp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (en)
            s1_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_x_reg    <= x20;
            s1_cx_reg   <= cx_in;
            s1_band_reg <= ({ady, 1'b0} < {3'b000, dq});
            s1_last_reg <= in_last;
            s1_t2_reg   <= {ady[24:0], 1'b0};
            s1_hp_reg   <= 39'(cfg.thickness) * 39'(cfg.tan_a);
        end
    end

    // stage 2: squares, half shift
    logic        s2_v_reg;
    side_t       s2_side_reg;
    logic [51:0] s2_sqd_reg;
    logic [51:0] s2_sqa_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else if (en)
            s2_v_reg <= s1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_side_reg.x    <= s1_x_reg;
            s2_side_reg.cx   <= s1_cx_reg;
            s2_side_reg.h    <= 33'((40'(s1_hp_reg) + 40'd64) >> 7);
            s2_side_reg.band <= s1_band_reg;
            s2_side_reg.last <= s1_last_reg;
            s2_sqd_reg       <= 52'(dq) * 52'(dq);
            s2_sqa_reg       <= 52'(s1_t2_reg) * 52'(s1_t2_reg);
        end
    end

    // stage 3 loads the root pipeline, two result bits per stage
    logic        sq_v   [0:SQ_N];
    sq_t         sq_st  [0:SQ_N];
    logic [51:0] sq_rad [0:SQ_N];
    side_t       sq_side[0:SQ_N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_v[0] <= 1'b0;
        else if (en)
            sq_v[0] <= s2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_st[0]   <= '0;
            sq_rad[0]  <= s2_sqd_reg - s2_sqa_reg;
            sq_side[0] <= s2_side_reg;
        end
    end

    for (genvar s = 0; s < SQ_N; s++)
    begin : g_sq
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_v[s+1] <= 1'b0;
            else if (en)
                sq_v[s+1] <= sq_v[s];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_st[s+1]   <= sq_step(sq_step(sq_st[s], sq_rad[s][51:50]),
                                        sq_rad[s][49:48]);
                sq_rad[s+1]  <= {sq_rad[s][47:0], 4'b0};
                sq_side[s+1] <= sq_side[s];
            end
        end
    end

    // stage A: products of the inner chord
    logic        sa_v_reg;
    side_t       sa_side_reg;
    logic [42:0] sa_lp_reg;
    logic [47:0] sa_sp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sa_v_reg <= 1'b0;
        else if (en)
            sa_v_reg <= sq_v[SQ_N];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_side_reg <= sq_side[SQ_N];
            sa_lp_reg   <= 43'(sq_st[SQ_N].root) * 43'(cfg.sec_a);
            sa_sp_reg   <= 48'(sq_st[SQ_N].root) * 48'(cfg.csc_a);
        end
    end

    // stage B: round
    logic        sb_v_reg;
    side_t       sb_side_reg;
    logic [26:0] sb_l_reg;
    logic [32:0] sb_slant_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sb_v_reg <= 1'b0;
        else if (en)
            sb_v_reg <= sa_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_side_reg  <= sa_side_reg;
            sb_l_reg     <= 27'((44'(sa_lp_reg) + 44'd65536) >> 17);
            sb_slant_reg <= 33'((49'(sa_sp_reg) + 49'd32768) >> 16);
        end
    end

    // stage C: window edges
    logic signed [35:0] cx36;
    logic signed [35:0] h36;
    logic signed [35:0] l36;

    assign cx36 = {{(36-CX_W){sb_side_reg.cx[CX_W-1]}}, sb_side_reg.cx};
    assign h36  = {3'b000, sb_side_reg.h};
    assign l36  = {9'b0, sb_l_reg};

    logic               sc_v_reg;
    logic signed [24:0] sc_x_reg;
    logic               sc_band_reg;
    logic               sc_last_reg;
    logic [32:0]        sc_slant_reg;
    logic signed [35:0] sc_xmax_reg;
    logic signed [35:0] sc_xmin_reg;
    logic signed [35:0] sc_xr1_reg;
    logic signed [35:0] sc_xr2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sc_v_reg <= 1'b0;
        else if (en)
            sc_v_reg <= sb_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc_x_reg     <= sb_side_reg.x;
            sc_band_reg  <= sb_side_reg.band;
            sc_last_reg  <= sb_side_reg.last;
            sc_slant_reg <= sb_slant_reg;
            sc_xmax_reg  <= cx36 + h36 + l36;
            sc_xmin_reg  <= cx36 - h36 - l36;
            sc_xr1_reg   <= cx36 + h36 - l36;
            sc_xr2_reg   <= cx36 - h36 + l36;
        end
    end

    // stage D: pick the chord piece
    logic signed [35:0] x36;
    logic signed [35:0] d_hi;
    logic signed [35:0] d_lo;
    mode_t              mode;
    logic               use_hi;

    assign x36  = {{11{sc_x_reg[24]}}, sc_x_reg};
    assign d_hi = sc_xmax_reg - x36;
    assign d_lo = x36 - sc_xmin_reg;

    always_comb
    begin
        mode   = M_ZERO;
        use_hi = 1'b0;
        if (sc_band_reg && x36 > sc_xmin_reg && x36 < sc_xmax_reg)
        begin
            if (sc_xr1_reg > sc_xr2_reg)
            begin
                if (x36 > sc_xr2_reg && x36 < sc_xr1_reg)
                    mode = M_SLANT;
                else if (x36 > sc_xr1_reg)
                begin
                    mode   = M_RAMP;
                    use_hi = 1'b1;
                end
                else if (x36 < sc_xr2_reg)
                    mode = M_RAMP;
            end
            else if (sc_xr2_reg > sc_xr1_reg)
            begin
                if (x36 > sc_xr1_reg && x36 < sc_xr2_reg)
                    mode = M_FULL;
                else if (x36 > sc_xr2_reg)
                begin
                    mode   = M_RAMP;
                    use_hi = 1'b1;
                end
                else if (x36 < sc_xr1_reg)
                    mode = M_RAMP;
            end
        end
    end

    logic        sd_v_reg;
    logic        sd_last_reg;
    mode_t       sd_mode_reg;
    logic [32:0] sd_slant_reg;
    logic [32:0] sd_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sd_v_reg <= 1'b0;
        else if (en)
            sd_v_reg <= sc_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd_last_reg  <= sc_last_reg;
            sd_mode_reg  <= mode;
            sd_slant_reg <= sc_slant_reg;
            sd_d_reg     <= use_hi ? d_hi[32:0] : d_lo[32:0];
        end
    end

    // stage E: ramp partial products
    logic        se_v_reg;
    logic        se_last_reg;
    mode_t       se_mode_reg;
    logic [32:0] se_slant_reg;
    logic [38:0] se_plo_reg;
    logic [37:0] se_phi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            se_v_reg <= 1'b0;
        else if (en)
            se_v_reg <= sd_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            se_last_reg  <= sd_last_reg;
            se_mode_reg  <= sd_mode_reg;
            se_slant_reg <= sd_slant_reg;
            se_plo_reg   <= 39'(sd_d_reg[16:0]) * 39'(cfg.cot_a);
            se_phi_reg   <= 38'(sd_d_reg[32:17]) * 38'(cfg.cot_a);
        end
    end

    // stage F: chord value
    logic [55:0]        ramp_sum;
    logic [CHORD_W-1:0] chord_next;

    assign ramp_sum = {1'b0, se_phi_reg, 17'b0} + 56'(se_plo_reg) + 56'd32768;

    always_comb
    begin
        case (se_mode_reg)
            M_SLANT: chord_next = CHORD_W'(se_slant_reg);
            M_FULL:  chord_next = CHORD_W'({cfg.thickness, 10'b0});
            M_RAMP:  chord_next = ramp_sum[55:16];
            default: chord_next = '0;
        endcase
    end

    logic               sf_v_reg;
    logic               sf_last_reg;
    logic [CHORD_W-1:0] sf_chord_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sf_v_reg <= 1'b0;
        else if (en)
            sf_v_reg <= se_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sf_last_reg  <= se_last_reg;
            sf_chord_reg <= chord_next;
        end
    end

    assign chord_valid = sf_v_reg;
    assign chord_last  = sf_last_reg;
    assign chord       = sf_chord_reg;

endmodule

@@ sv/channel_array_effective_length.sv @@
// Channel   | Direction | Handshake            | Payload
// input     | in        | in_valid / in_stall  | x_pos, y_pos
// result    | out       | out_valid / out_stall| effective_length
// config    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item is 3*OUTER_ROW_CHANNELS+1 lattice channels (61 by default): the sequencer
// issues one channel per cycle into the chord pipeline unless a held result stalls it.
// A result passes the chord pipeline, the sum register and the output register.
// Reset loads the default geometry and angle words; there is no clearing pass.
// A held result under out_stall freezes the sequencer and every pipeline stage.
module channel_array_effective_length
    import caef_pkg::*;
#(
    parameter int OUTER_ROW_CHANNELS = OUTER_ROW_CHANNELS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [POS_W-1:0]  x_pos,
    input  logic signed [POS_W-1:0]  y_pos,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [OUT_W-1:0]  effective_length,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [IDX_W-1:0]         cfg_index,
    input  logic [DATA_W-1:0]        cfg_data
);

    localparam int KW = $clog2(2 * OUTER_ROW_CHANNELS + 1);
    localparam logic [KW-1:0] K_LAST = KW'(2 * OUTER_ROW_CHANNELS);
    localparam logic [6:0] N_CONST = 7'(OUTER_ROW_CHANNELS);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.diameter  <= DIAMETER_RST;
            cfg_reg.pitch     <= PITCH_RST;
            cfg_reg.thickness <= THICKNESS_RST;
            cfg_reg.tan_a     <= TAN_RST;
            cfg_reg.sec_a     <= SEC_RST;
            cfg_reg.cot_a     <= COT_RST;
            cfg_reg.csc_a     <= CSC_RST;
        end
        else if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_DIAMETER:  cfg_reg.diameter  <= cfg_data[15:0];
                REG_PITCH:     cfg_reg.pitch     <= cfg_data[15:0];
                REG_THICKNESS: cfg_reg.thickness <= cfg_data;
                REG_TAN:       cfg_reg.tan_a     <= cfg_data[16:0];
                REG_SEC:       cfg_reg.sec_a     <= cfg_data[16:0];
                REG_COT:       cfg_reg.cot_a     <= cfg_data;
                REG_CSC:       cfg_reg.csc_a     <= cfg_data;
                default:       ;
            endcase
        end
    end

    // lattice geometry from the pitch
    logic [24:0]            half;
    logic [31:0]            cx_mag;
    logic signed [CX_W-1:0] cx_start;
    logic [31:0]            yrow_prod;
    logic [25:0]            yrow;
    logic signed [CY_W-1:0] cy_pos;

    assign half      = {cfg_reg.pitch, 9'b0};
    assign cx_mag    = {7'b0, half} * {25'b0, N_CONST};
    assign cx_start  = -$signed({1'b0, cx_mag});
    assign yrow_prod = 32'(cfg_reg.pitch) * 32'(SQRT3_HALF_Q16) + 32'd32;
    assign yrow      = yrow_prod[31:6];
    assign cy_pos    = $signed({1'b0, yrow});

    // sequencer
    logic                    en;
    logic                    accept;
    logic                    issue;
    logic                    at_last;
    logic                    busy_reg;
    logic [KW-1:0]           k_reg;
    logic                    sub_reg;
    logic signed [CX_W-1:0]  cx_reg;
    logic signed [POS_W-1:0] x_reg;
    logic signed [POS_W-1:0] y_reg;
    logic signed [CY_W-1:0]  cy;
    logic                    out_valid_reg;

    assign en       = !(out_valid_reg && out_stall);
    assign at_last  = (k_reg == K_LAST);
    assign issue    = busy_reg && en;
    assign in_stall = !en || (busy_reg && !at_last);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        case ({k_reg[0], sub_reg})
            2'b10:   cy = cy_pos;
            2'b11:   cy = -cy_pos;
            default: cy = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
            sub_reg  <= 1'b0;
        end
        else if (accept)
        begin
            busy_reg <= 1'b1;
            k_reg    <= '0;
            sub_reg  <= 1'b0;
        end
        else if (issue)
        begin
            if (at_last)
                busy_reg <= 1'b0;
            else if (!k_reg[0] || sub_reg)
            begin
                k_reg   <= k_reg + 1'b1;
                sub_reg <= 1'b0;
            end
            else
                sub_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg  <= x_pos;
            y_reg  <= y_pos;
            cx_reg <= cx_start;
        end
        else if (issue && (!k_reg[0] || sub_reg))
            cx_reg <= cx_reg + $signed({8'b0, half});
    end

    logic               ch_valid;
    logic               ch_last;
    logic [CHORD_W-1:0] ch_chord;

    caef_chord u_chord
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (issue),
        .in_last     (at_last),
        .x_in        (x_reg),
        .y_in        (y_reg),
        .cx_in       (cx_reg),
        .cy_in       (cy),
        .cfg         (cfg_reg),
        .chord_valid (ch_valid),
        .chord_last  (ch_last),
        .chord       (ch_chord)
    );

    // sum the chords of one item
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] fin_reg;
    logic             fin_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            fin_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            fin_valid_reg <= ch_valid && ch_last;
            if (ch_valid)
            begin
                if (ch_last)
                    acc_reg <= '0;
                else
                    acc_reg <= acc_reg + ACC_W'(ch_chord);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && ch_valid && ch_last)
            fin_reg <= acc_reg + ACC_W'(ch_chord);
    end

    // thickness minus sum, round half up, clamp
    logic signed [ACC_W:0]   diff;
    logic signed [ACC_W:0]   rnd;
    logic signed [ACC_W-10:0] q;
    logic signed [OUT_W-1:0] sat;

    assign diff = $signed({1'b0, (ACC_W)'({cfg_reg.thickness, 10'b0})})
                - $signed({1'b0, fin_reg});
    assign rnd  = diff + (ACC_W+1)'(512);
    assign q    = rnd[ACC_W:10];

    always_comb
    begin
        if (q > (ACC_W-9)'(4194303))
            sat = OUT_W'(4194303);
        else if (q < -(ACC_W-9)'(4194304))
            sat = -OUT_W'(4194304);
        else
            sat = q[OUT_W-1:0];
    end

    logic signed [OUT_W-1:0] out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= fin_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en && fin_valid_reg)
            out_reg <= sat;
    end

    assign out_valid        = out_valid_reg;
    assign effective_length = out_reg;

    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> k_reg <= K_LAST)
        else $error("channel index past the lattice");

    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg && k_reg == '0 && !sub_reg)
        else $error("sequencer did not restart on a transfer");

    a_sub_odd: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg |-> k_reg[0])
        else $error("lower row selected on a middle-row column");

    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_valid_reg && !en) |=> fin_valid_reg && $stable(fin_reg))
        else $error("pending sum changed while the output was held");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import caef_pkg::*;

    localparam int NCH = OUTER_ROW_CHANNELS_DEF;
    localparam int DRAIN_CYCLES = 200;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [POS_W-1:0] x_pos = '0;
    logic signed [POS_W-1:0] y_pos = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [OUT_W-1:0] effective_length;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0] cfg_data = '0;

    channel_array_effective_length u_top (.*);

    always #5 clk = ~clk;

    // local copy of the geometry and angle registers
    cfg_t geom;

    logic signed [OUT_W-1:0] length_queue[$];
    int errors = 0;
    int n_results = 0;
    int n_items = 0;
    int idle_cycles = 0;
    bit send_gaps = 1'b1;
    bit recv_gaps = 1'b1;
    bit recv_hold = 1'b0;

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint slope_ramp(longint d);
        longint unsigned p;
        p = longint'(d) * longint'(geom.cot_a) + 32768;
        return longint'(p >> 16);
    endfunction

    function automatic longint chord_len(longint x, longint y, longint cx, longint cy);
        longint dy, h, l, xmax, xmin, xr1, xr2;
        longint unsigned ady, dq, li;
        dy = y - cy;
        ady = (dy < 0) ? -dy : dy;
        dq = longint'(geom.diameter) << 10;
        if (2 * ady >= dq) return 0;
        li = isqrt(dq * dq - 4 * ady * ady);
        h = (longint'(geom.thickness) * longint'(geom.tan_a) + 64) >>> 7;
        l = longint'((li * longint'(geom.sec_a) + 65536) >> 17);
        xmax = cx + h + l;
        xmin = cx - h - l;
        xr1 = cx + h - l;
        xr2 = cx - h + l;
        if (!(x > xmin && x < xmax)) return 0;
        if (xr1 > xr2)
        begin
            if (x > xr2 && x < xr1) return longint'((li * longint'(geom.csc_a) + 32768) >> 16);
            if (x > xr1) return slope_ramp(xmax - x);
            if (x < xr2) return slope_ramp(x - xmin);
        end
        else if (xr2 > xr1)
        begin
            if (x > xr1 && x < xr2) return longint'(geom.thickness) << 10;
            if (x > xr2) return slope_ramp(xmax - x);
            if (x < xr1) return slope_ramp(x - xmin);
        end
        return 0;
    endfunction

    function automatic logic signed [OUT_W-1:0] predict_length(logic signed [POS_W-1:0] xp,
                                                              logic signed [POS_W-1:0] yp);
        longint x, y, half, yrow, sum, v, r, q, cx;
        x = longint'(xp) * 1024;
        y = longint'(yp) * 1024;
        half = longint'(geom.pitch) * 512;
        yrow = (longint'(geom.pitch) * SQRT3_HALF_Q16 + 32) >>> 6;
        sum = 0;
        for (int k = 0; k <= 2 * NCH; k++)
        begin
            cx = longint'(k - NCH) * half;
            if (k % 2 == 1)
                sum += chord_len(x, y, cx, yrow) + chord_len(x, y, cx, -yrow);
            else
                sum += chord_len(x, y, cx, 0);
        end
        v = (longint'(geom.thickness) << 10) - sum;
        r = v + 512;
        if (r >= 0) q = r / 1024;
        else q = -((-r + 1023) / 1024);
        if (q > 4194303) q = 4194303;
        if (q < -4194304) q = -4194304;
        return q[OUT_W-1:0];
    endfunction

    // receiver: random stall bursts plus an optional long hold
    initial
    begin
        int burst;
        burst = 0;
        forever
        begin
            @(negedge clk);
            if (recv_hold)
                out_stall <= 1'b1;
            else if (burst > 0)
            begin
                burst--;
                out_stall <= 1'b1;
            end
            else if (recv_gaps && $urandom_range(0, 9) == 0)
            begin
                burst = $urandom_range(1, 12) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // check each result transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (length_queue.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %0d", $time, effective_length);
            end
            else
            begin
                logic signed [OUT_W-1:0] want;
                want = length_queue.pop_front();
                if (want !== effective_length)
                begin
                    errors++;
                    $display("%0t: effective_length expected %0d actual %0d",
                             $time, want, effective_length);
                end
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_item(logic signed [POS_W-1:0] xp, logic signed [POS_W-1:0] yp);
        if (send_gaps && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        in_valid <= 1'b1;
        x_pos <= xp;
        y_pos <= yp;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        length_queue.push_back(predict_length(xp, yp));
        n_items++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (length_queue.size() != 0) @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    // leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(reg_idx_t idx, int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= DATA_W'(val);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_DIAMETER:  geom.diameter = val[15:0];
            REG_PITCH:     geom.pitch = val[15:0];
            REG_THICKNESS: geom.thickness = val[21:0];
            REG_TAN:       geom.tan_a = val[16:0];
            REG_SEC:       geom.sec_a = val[16:0];
            REG_COT:       geom.cot_a = val[21:0];
            REG_CSC:       geom.csc_a = val[21:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic write_geometry(int d, int s, int t, int tn, int sc, int ct, int cs);
        write_reg(REG_DIAMETER, d);
        write_reg(REG_PITCH, s);
        write_reg(REG_THICKNESS, t);
        write_reg(REG_TAN, tn);
        write_reg(REG_SEC, sc);
        write_reg(REG_COT, ct);
        write_reg(REG_CSC, cs);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [POS_W-1:0] rand_pos();
        return POS_W'($urandom);
    endfunction

    // positions near the lattice: small coordinates hit channels
    function automatic logic signed [POS_W-1:0] near_pos(int span);
        return POS_W'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic test_directed();
        logic signed [POS_W-1:0] ext[5] = '{-16384, -1, 0, 1, 16383};
        foreach (ext[i])
            foreach (ext[j])
                if (i == j || i + j == 4)
                    send_item(ext[i], ext[j]);
        // channel centre, band edges, ramps, outer rows
        send_item(0, 3);
        send_item(8, 7);
        send_item(2, -7);
        send_item(4, 0);
        send_item(-4, 2);
        send_item(16, 0);
        send_item(12, 3);
        send_item(-12, -3);
        drain();
    endtask

    task automatic test_random(int count, int span);
        repeat (count)
        begin
            if ($urandom_range(0, 3) == 0)
                send_item(rand_pos(), rand_pos());
            else
                send_item(near_pos(span), near_pos(span));
        end
    endtask

    task automatic test_settings();
        // small bore, zero tilt: middle part is full thickness
        write_geometry(1024, 1024, 1024, 0, 65536, 65536, 65536);
        test_random(80, 40);
        drain();
        // extremes: largest everything
        write_geometry(65535, 65535, 4194303, 65536, 92682, 3801088, 3801088);
        test_random(80, 16384);
        drain();
        // narrow channels, thick plate: middle part is the slant chord
        write_geometry(2048, 16384, 2000000, 65536, 92682, 65536, 92682);
        test_random(80, 200);
        drain();
        // random but legal words, including inconsistent trig
        repeat (3)
        begin
            write_geometry($urandom_range(1024, 65535), $urandom_range(1024, 65535),
                           $urandom_range(1024, 4194303), $urandom_range(0, 65536),
                           $urandom_range(65536, 92682), $urandom_range(65536, 3801088),
                           $urandom_range(65536, 3801088));
            test_random(60, 400);
            drain();
        end
        write_geometry(int'(DIAMETER_RST), int'(PITCH_RST), int'(THICKNESS_RST),
                       int'(TAN_RST), int'(SEC_RST), int'(COT_RST), int'(CSC_RST));
    endtask

    task automatic test_backpressure();
        fork
            begin
                recv_hold = 1'b1;
                repeat (400) @(negedge clk);
                recv_hold = 1'b0;
            end
            test_random(12, 100);
        join
        drain();
    endtask

    initial
    begin
        geom = '{DIAMETER_RST, PITCH_RST, THICKNESS_RST, TAN_RST, SEC_RST, COT_RST, CSC_RST};
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_settings();
        test_backpressure();
        test_random(350, 100);
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        test_random(100, 100);
        in_valid <= 1'b0;
        fork
            while (length_queue.size() != 0) @(negedge clk);
            begin
                repeat (200000) @(negedge clk);
                $display("FAILURE");
                $finish;
            end
        join_any
        disable fork;
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Sent %0d positions over reset, extreme and random geometries;", n_items);
        $display("checked %0d effective lengths, %0d mismatches.", n_results, errors);
        if (errors == 0 && length_queue.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
